FILE: design/buddy_block_allocator_macros.svh
// Assertion macros shared by the allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define BBA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle
`define BBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    localparam int LEAVES_DEF        = 4096;
    localparam int TOP_ORDER_DEF     = 8;
    localparam int GRANULE_BYTES_DEF = 4096;

    // Block status codes
    typedef enum logic [1:0] {
        ST_FREE = 2'd0,
        ST_INV  = 2'd1,
        ST_OCC  = 2'd2
    } status_t;

    // Request codes
    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } func_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_SIZE,
        S_A_SCAN,
        S_A_UNL,
        S_A_SPLIT,
        S_PUSH,
        S_PUSH_LINK,
        S_F_CHK,
        S_F_BRD,
        S_F_BCHK,
        S_F_MRG,
        S_DONE
    } state_t;

endpackage

FILE: design/buddy_block_allocator.sv
`timescale 1ns / 1ps
// Buddy allocator: one transaction at a time; in_stall is high from acceptance until the
// result enters the output register, so a new transaction waits for the last one's result.
// An allocate splits one order per pass through S_A_SPLIT and a free merges one order per
// step; an oversize allocate and an out-of-range free go straight to DONE.
// A result held by out_stall holds the next result in DONE.
// Reset sets the list heads at once, then a pass over every entry rebuilds the block table.

module buddy_block_allocator #(
    parameter int LEAVES        = bba_pkg::LEAVES_DEF,
    parameter int TOP_ORDER     = bba_pkg::TOP_ORDER_DEF,
    parameter int GRANULE_BYTES = bba_pkg::GRANULE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [20:0] size_bytes,
    input  logic [11:0] block_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [11:0] granted_index,
    output logic [3:0]  granted_order
);

    `include "buddy_block_allocator_macros.svh"

    localparam int IW = $clog2(LEAVES);
    localparam int LW = IW + 1;
    localparam int OW = $clog2(TOP_ORDER + 1);
    localparam logic [LW-1:0] NIL = LW'(LEAVES);
    localparam longint MAXB = longint'(GRANULE_BYTES) << TOP_ORDER;
    localparam longint TOTB = longint'(LEAVES) * longint'(GRANULE_BYTES);
    localparam longint LIMB = (MAXB < TOTB) ? MAXB : TOTB;
    localparam int STEP = 1 << TOP_ORDER;
    localparam longint GRAN2 = longint'(GRANULE_BYTES) << 1;
    localparam logic [21:0] GRAN2_SAT = (GRAN2 > 64'h3FFFFF) ? 22'h3FFFFF : 22'(GRAN2);

    typedef struct packed {
        logic [OW-1:0]    ord;
        bba_pkg::status_t st;
    } meta_t;

    // Block table: order and status, previous link, next link; one port each, registered read
    meta_t         meta_mem [LEAVES];
    logic [LW-1:0] prv_mem  [LEAVES];
    logic [LW-1:0] nxt_mem  [LEAVES];
    logic          meta_we, prv_we, nxt_we;
    logic [IW-1:0] meta_addr, prv_addr, nxt_addr;
    meta_t         meta_wd;
    logic [LW-1:0] prv_wd, nxt_wd;
    meta_t         meta_rd_reg;
    logic [LW-1:0] prv_rd_reg, nxt_rd_reg;

    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_addr] <= meta_wd;
        meta_rd_reg <= meta_mem[meta_addr];
        if (prv_we)
            prv_mem[prv_addr] <= prv_wd;
        prv_rd_reg <= prv_mem[prv_addr];
        if (nxt_we)
            nxt_mem[nxt_addr] <= nxt_wd;
        nxt_rd_reg <= nxt_mem[nxt_addr];
    end

    // Free list heads
    logic [LW-1:0] first_reg [TOP_ORDER+1];
    logic          first_we;
    logic [OW-1:0] first_sel;
    logic [LW-1:0] first_wd;

    bba_pkg::state_t state_reg, state_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [OW-1:0] want_reg, want_next, cur_reg, cur_next;
    logic [LW-1:0] node_reg, node_next, bud_reg, bud_next;
    logic [LW-1:0] q_reg, q_next;
    logic [LW-1:0] push_reg, push_next;
    logic [20:0]   size_reg, size_next;
    logic [21:0]   gran_reg, gran_next;
    logic          rok_reg, rok_next;
    logic [11:0]   ridx_reg, ridx_next;
    logic [3:0]    rord_reg, rord_next;
    logic          ok_reg, ok_next;
    logic [11:0]   gidx_reg, gidx_next;
    logic [3:0]    gord_reg, gord_next;
    logic          ov_reg, ov_next;
    logic          pret_reg, pret_next; // 0 return to split, 1 finish
    logic [LW-1:0] head_w;
    logic [LW-1:0] bud_w;
    logic [OW-1:0] cdec_w;
    logic [LW-1:0] sbud_w;

    assign in_stall  = (state_reg != bba_pkg::S_IDLE);
    assign out_valid = ov_reg;
    assign ok        = ok_reg;
    assign granted_index = gidx_reg;
    assign granted_order = gord_reg;
    assign head_w = first_reg[cur_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= TOP_ORDER; k++)
                first_reg[k] <= (k == TOP_ORDER) ? '0 : NIL;
        end
        else if (first_we)
            first_reg[first_sel] <= first_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::S_CLEAR;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg <= want_next;
        cur_reg  <= cur_next;
        node_reg <= node_next;
        bud_reg  <= bud_next;
        q_reg    <= q_next;
        push_reg <= push_next;
        size_reg <= size_next;
        gran_reg <= gran_next;
        rok_reg  <= rok_next;
        ridx_reg <= ridx_next;
        rord_reg <= rord_next;
        ok_reg   <= ok_next;
        gidx_reg <= gidx_next;
        gord_reg <= gord_next;
        pret_reg <= pret_next;
    end

    // Buddy of the node at the current order, and at one order below
    assign bud_w  = node_reg ^ (LW'(1) << cur_reg);
    assign cdec_w = cur_reg - OW'(1);
    assign sbud_w = node_reg ^ (LW'(1) << cdec_w);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        want_next = want_reg;
        cur_next = cur_reg;
        node_next = node_reg;
        bud_next = bud_reg;
        q_next = q_reg;
        push_next = push_reg;
        size_next = size_reg;
        gran_next = gran_reg;
        rok_next = rok_reg;
        ridx_next = ridx_reg;
        rord_next = rord_reg;
        ok_next = ok_reg;
        gidx_next = gidx_reg;
        gord_next = gord_reg;
        pret_next = pret_reg;
        ov_next = ov_reg && out_stall;
        meta_we = 1'b0;
        prv_we = 1'b0;
        nxt_we = 1'b0;
        meta_addr = node_reg[IW-1:0];
        prv_addr = node_reg[IW-1:0];
        nxt_addr = node_reg[IW-1:0];
        meta_wd = meta_rd_reg;
        prv_wd = NIL;
        nxt_wd = NIL;
        first_we = 1'b0;
        first_sel = cur_reg;
        first_wd = NIL;

        unique case (state_reg)
            // Sweep the table into its reset image
            bba_pkg::S_CLEAR:
            begin
                meta_we = 1'b1;
                prv_we = 1'b1;
                nxt_we = 1'b1;
                meta_addr = cnt_reg[IW-1:0];
                prv_addr = cnt_reg[IW-1:0];
                nxt_addr = cnt_reg[IW-1:0];
                if ((cnt_reg & LW'(STEP - 1)) == '0)
                begin
                    meta_wd.ord = OW'(TOP_ORDER);
                    meta_wd.st  = bba_pkg::ST_FREE;
                    prv_wd = (cnt_reg == '0) ? NIL : cnt_reg - LW'(STEP);
                    nxt_wd = ((LW+1)'(cnt_reg) + (LW+1)'(STEP) < (LW+1)'(LEAVES))
                             ? cnt_reg + LW'(STEP) : NIL;
                end
                else
                begin
                    meta_wd.ord = '0;
                    for (int k = TOP_ORDER - 1; k >= 0; k--)
                        if (cnt_reg[k])
                            meta_wd.ord = OW'(k);
                    meta_wd.st = bba_pkg::ST_INV;
                end
                cnt_next = cnt_reg + LW'(1);
                if (cnt_reg == LW'(LEAVES - 1))
                    state_next = bba_pkg::S_IDLE;
            end
            // Take a transaction and start the read of the block to free
            bba_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    size_next = size_bytes;
                    gran_next = GRAN2_SAT;
                    node_next = LW'(block_index);
                    rok_next = 1'b0;
                    ridx_next = '0;
                    rord_next = '0;
                    want_next = OW'(1);
                    meta_addr = IW'(block_index);
                    if (func == bba_pkg::FN_ALLOC)
                        state_next = (longint'(size_bytes) > LIMB) ? bba_pkg::S_DONE
                                                                  : bba_pkg::S_A_SIZE;
                    else if (LW'(block_index) >= NIL)
                        state_next = bba_pkg::S_DONE;
                    else
                        state_next = bba_pkg::S_F_CHK;
                end
            end
            // Round size up, one order a cycle
            bba_pkg::S_A_SIZE:
            begin
                if (want_reg < OW'(TOP_ORDER) && gran_reg < {1'b0, size_reg})
                begin
                    want_next = want_reg + OW'(1);
                    gran_next = gran_reg[21] ? 22'h3FFFFF : {gran_reg[20:0], 1'b0};
                end
                else
                begin
                    cur_next = want_reg;
                    state_next = bba_pkg::S_A_SCAN;
                end
            end
            // Find lowest non-empty list, read the head's next link
            bba_pkg::S_A_SCAN:
            begin
                if (head_w != NIL)
                begin
                    node_next = head_w;
                    nxt_addr = head_w[IW-1:0];
                    state_next = bba_pkg::S_A_UNL;
                end
                else if (cur_reg == OW'(TOP_ORDER))
                    state_next = bba_pkg::S_DONE;
                else
                    cur_next = cur_reg + OW'(1);
            end
            // Unlink the head: advance the list head, mark the block occupied
            bba_pkg::S_A_UNL:
            begin
                first_we = 1'b1;
                first_wd = nxt_rd_reg;
                if (nxt_rd_reg != NIL)
                begin
                    prv_we = 1'b1;
                    prv_addr = nxt_rd_reg[IW-1:0];
                    prv_wd = NIL;
                end
                meta_we = 1'b1;
                meta_wd.ord = cur_reg;
                meta_wd.st = bba_pkg::ST_OCC;
                state_next = bba_pkg::S_A_SPLIT;
            end
            // Split one order down, or finish
            bba_pkg::S_A_SPLIT:
            begin
                if (cur_reg > want_reg)
                begin
                    cur_next = cdec_w;
                    meta_we = 1'b1;
                    meta_wd.ord = cdec_w;
                    meta_wd.st = bba_pkg::ST_OCC;
                    if (sbud_w < NIL)
                    begin
                        push_next = sbud_w;
                        pret_next = 1'b0;
                        state_next = bba_pkg::S_PUSH;
                    end
                end
                else
                begin
                    rok_next = 1'b1;
                    ridx_next = 12'(node_reg);
                    rord_next = 4'(cur_reg);
                    state_next = bba_pkg::S_DONE;
                end
            end
            // Push a block on the head of its list
            bba_pkg::S_PUSH:
            begin
                meta_addr = push_reg[IW-1:0];
                prv_addr = push_reg[IW-1:0];
                nxt_addr = push_reg[IW-1:0];
                meta_we = 1'b1;
                meta_wd.ord = cur_reg;
                meta_wd.st = bba_pkg::ST_FREE;
                prv_we = 1'b1;
                prv_wd = NIL;
                nxt_we = 1'b1;
                nxt_wd = head_w;
                first_we = 1'b1;
                first_wd = push_reg;
                q_next = head_w;
                state_next = bba_pkg::S_PUSH_LINK;
            end
            // Link the old head back to the pushed block
            bba_pkg::S_PUSH_LINK:
            begin
                if (q_reg != NIL)
                begin
                    prv_we = 1'b1;
                    prv_addr = q_reg[IW-1:0];
                    prv_wd = push_reg;
                end
                if (pret_reg)
                begin
                    rok_next = 1'b1;
                    ridx_next = '0;
                    rord_next = 4'(cur_reg);
                    state_next = bba_pkg::S_DONE;
                end
                else
                    state_next = bba_pkg::S_A_SPLIT;
            end
            // Free: check the target is an occupied block
            bba_pkg::S_F_CHK:
            begin
                if (meta_rd_reg.st != bba_pkg::ST_OCC)
                    state_next = bba_pkg::S_DONE;
                else
                begin
                    cur_next = (meta_rd_reg.ord > OW'(TOP_ORDER)) ? OW'(TOP_ORDER)
                                                                  : meta_rd_reg.ord;
                    state_next = bba_pkg::S_F_BRD;
                end
            end
            // Read buddy, or push the block when at the top order or the buddy is out of range
            bba_pkg::S_F_BRD:
            begin
                bud_next = bud_w;
                meta_addr = bud_w[IW-1:0];
                prv_addr = bud_w[IW-1:0];
                nxt_addr = bud_w[IW-1:0];
                if (cur_reg >= OW'(TOP_ORDER) || bud_w >= NIL)
                begin
                    push_next = node_reg;
                    pret_next = 1'b1;
                    state_next = bba_pkg::S_PUSH;
                end
                else
                    state_next = bba_pkg::S_F_BCHK;
            end
            // Merge with buddy if free at same order: drop it and unlink it
            bba_pkg::S_F_BCHK:
            begin
                if (meta_rd_reg.st != bba_pkg::ST_FREE || meta_rd_reg.ord != cur_reg)
                begin
                    push_next = node_reg;
                    pret_next = 1'b1;
                    state_next = bba_pkg::S_PUSH;
                end
                else
                begin
                    meta_addr = bud_reg[IW-1:0];
                    meta_we = 1'b1;
                    meta_wd.st = bba_pkg::ST_INV;
                    if (prv_rd_reg != NIL)
                    begin
                        nxt_we = 1'b1;
                        nxt_addr = prv_rd_reg[IW-1:0];
                        nxt_wd = nxt_rd_reg;
                    end
                    else
                    begin
                        first_we = 1'b1;
                        first_wd = nxt_rd_reg;
                    end
                    if (nxt_rd_reg != NIL)
                    begin
                        prv_we = 1'b1;
                        prv_addr = nxt_rd_reg[IW-1:0];
                        prv_wd = prv_rd_reg;
                    end
                    state_next = bba_pkg::S_F_MRG;
                end
            end
            // Move up one order; the lower of the pair heads the merged block
            bba_pkg::S_F_MRG:
            begin
                if (bud_reg < node_reg)
                begin
                    meta_we = 1'b1;
                    meta_wd.ord = cur_reg;
                    meta_wd.st = bba_pkg::ST_INV;
                    node_next = bud_reg;
                end
                cur_next = cur_reg + OW'(1);
                state_next = bba_pkg::S_F_BRD;
            end
            // Hand the result to the output register once it is free
            bba_pkg::S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    ok_next = rok_reg;
                    gidx_next = ridx_reg;
                    gord_next = rord_reg;
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    `BBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(ok) && $stable(granted_index) && $stable(granted_order))
    `BBA_ASSERT_IMPL(a_fail_zero, out_valid && !ok, granted_index == '0 && granted_order == '0)
    `BBA_ASSERT_IMPL(a_ok_order, out_valid && ok, granted_order != '0 && granted_order <= 4'(TOP_ORDER))
    `BBA_ASSERT_IMPL(a_clear_quiet, state_reg == bba_pkg::S_CLEAR, !out_valid && in_stall)

endmodule
